[sv/iqas_pkg.sv]
// ----------------------------------------------------------------------------
// iqas_pkg
// shared constants, types and helpers of the iq amplitude statistics core
// ----------------------------------------------------------------------------
package iqas_pkg;

    localparam int MAX_PAIRS = 117;
    localparam int ADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
    localparam int AMP_W     = 16;
    localparam int SUM_W     = AMP_W + CNT_W;
    localparam int SQ_W      = 16 + CNT_W;
    localparam int DVD_W     = SQ_W + 16;
    localparam int RAD_W     = 2 * ((DVD_W + 1) / 2) + 2;
    localparam int ROOT_W    = RAD_W / 2;

    localparam logic [15:0] Q_LOW  = 16'd6554;
    localparam logic [15:0] Q_MID  = 16'd32768;
    localparam logic [15:0] Q_HIGH = 16'd58982;

    typedef enum logic [1:0] {
        QS_LOW  = 2'd0,
        QS_MID  = 2'd1,
        QS_HIGH = 2'd2
    } t_qsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AMP,
        S_INS,
        S_INS_LAST,
        S_UPD,
        S_MEAN_GO,
        S_MEAN_WT,
        S_EX2_GO,
        S_EX2_WT,
        S_VAR,
        S_SPR_WT,
        S_QPOS,
        S_QRDLO,
        S_QRDHI,
        S_QMUL,
        S_QSUM,
        S_OUT
    } t_state;

    // handshake between the sequencer and an iterative unit
    typedef struct packed {
        logic start;
    } t_unit_hs;

    function automatic logic [15:0] q_frac(input t_qsel sel);
        logic [15:0] v;
        case (sel)
            QS_LOW:  v = Q_LOW;
            QS_MID:  v = Q_MID;
            QS_HIGH: v = Q_HIGH;
            default: v = Q_MID;
        endcase
        return v;
    endfunction

endpackage

[sv/iqas_ram.sv]
// ----------------------------------------------------------------------------
// iqas_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module iqas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 117
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/iqas_sqrt.sv]
// ----------------------------------------------------------------------------
// iqas_sqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module iqas_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iqas_pkg::t_unit_hs     i_hs,
    input  logic [iqas_pkg::RAD_W-1:0]  i_radicand,
    output logic                   o_done,
    output logic [iqas_pkg::ROOT_W-1:0] o_root
);
    import iqas_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]    r_val;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [ROOT_W+1:0]   n_rem;
    logic [ROOT_W+1:0]   n_trial;

    always_comb begin
        n_rem   = {r_rem[ROOT_W-1:0], r_val[RAD_W-1 -: 2]};
        n_trial = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_hs.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ROOT_W);
                r_val  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (n_rem >= n_trial) begin
                    r_rem  <= n_rem - n_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

[sv/iqas_div.sv]
// ----------------------------------------------------------------------------
// iqas_div
// restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
module iqas_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  iqas_pkg::t_unit_hs         i_hs,
    input  logic [iqas_pkg::DVD_W-1:0] i_dividend,
    input  logic [iqas_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [iqas_pkg::DVD_W-1:0] o_quotient
);
    import iqas_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]    r_quo;
    logic [CNT_W:0]      r_rem;
    logic [CNT_W-1:0]    r_dvs;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [CNT_W:0]      n_rem;

    assign n_rem = {r_rem[CNT_W-1:0], r_quo[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_hs.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DVD_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_dvs}) begin
                    r_rem <= n_rem - {1'b0, r_dvs};
                    r_quo <= {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[DVD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

[sv/iq_amplitude_statistics_core.sv]
// ----------------------------------------------------------------------------
// iq_amplitude_statistics_core
// per-pair amplitude and per-packet mean, deviation and quantiles
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one beat per i/q pair, tlast marks the last pair of a
//   packet; rssi and noise floor ride along and are used on the last beat
//   master stream: one beat per input beat, tuser flags a counted pair,
//   tlast marks the packet end beat that carries the statistics
// sequence:
//   a counted pair runs the square root for its amplitude, then the
//   insertion into the sorted ram, which shifts each stored amplitude
//   above it up by one place; a pair beyond the cap skips both
//   the last pair adds the mean and mean square divisions, the square
//   root of the spread and the low, median and high quantile reads
//   the single ram read/write port pair and the shared iterative units
//   serialize this work; one pair is in work at a time
// reset: counters and sums clear, the sorted store is left as is since
//   only entries below the count are ever used
// stall: a finished beat waits in the output register; the next pair is
//   taken and worked on meanwhile, and its result waits for the slot
// ----------------------------------------------------------------------------
module iq_amplitude_statistics_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // i_sample[7:0], q_sample[15:8], rssi[23:16], floor_dbm[31:24]
    input  logic [31:0]  i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // amplitude[15:0], pair_count[22:16], mean_level[38:23], spread[54:39],
    // low_quantile[70:55], median_level[86:71], high_quantile[102:87],
    // signal_to_noise[111:103]
    output logic [111:0] o_m_tdata,
    // counted[0]
    output logic         o_m_tuser,
    output logic         o_m_tlast
);
    import iqas_pkg::*;

    t_state r_state, n_state;

    // per-pair and packet registers
    logic              r_last;
    logic              r_cnt_flag;
    logic signed [7:0] r_rssi, r_nf;
    logic [15:0]       r_energy;
    logic [AMP_W-1:0]  r_amp;
    logic [ADDR_W-1:0] r_j;
    logic [CNT_W-1:0]  r_pairs;
    logic [SUM_W-1:0]  r_asum;
    logic [SQ_W-1:0]   r_ssum;
    logic [CNT_W-1:0]  r_n;

    // statistics registers
    logic [15:0]       r_mean;
    logic [DVD_W-1:0]  r_ex2;
    logic [31:0]       r_m2;
    logic [15:0]       r_spread;
    t_qsel             r_qi;
    logic [ADDR_W-1:0] r_lo, r_hi;
    logic [15:0]       r_t;
    logic [15:0]       r_slo;
    logic [32:0]       r_pa;
    logic [31:0]       r_pb;
    logic [15:0]       r_ql, r_qm, r_qh;

    // output register
    logic              r_ovalid;
    logic [111:0]      r_odata;
    logic              r_ouser;
    logic              r_olast;

    // ram ports and unit control
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [AMP_W-1:0]  ram_wdata, ram_rdata;
    t_unit_hs          sq_hs, dv_hs;
    logic [RAD_W-1:0]  sq_rad;
    logic [ROOT_W-1:0] sq_root;
    logic [DVD_W-1:0]  dv_dvd;
    logic [DVD_W-1:0]  dv_quo;
    logic              sqd_done, dvd_done;

    logic              s_acc;
    logic              out_free;
    logic signed [15:0] in_isq, in_qsq;
    logic [15:0]       in_energy;
    logic [DVD_W-1:0]  var_val;
    logic [16+CNT_W-1:0] q_pos;
    logic [CNT_W-1:0]  n_m1;
    logic [ADDR_W-1:0] q_lo;
    logic [8:0]        snr;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;

    // energy of the incoming pair, at most 2 * 128 * 128
    assign in_isq    = $signed(i_s_tdata[7:0]) * $signed(i_s_tdata[7:0]);
    assign in_qsq    = $signed(i_s_tdata[15:8]) * $signed(i_s_tdata[15:8]);
    assign in_energy = 16'(in_isq) + 16'(in_qsq);

    assign var_val = (r_ex2 > DVD_W'(r_m2)) ? (r_ex2 - DVD_W'(r_m2)) : '0;
    assign n_m1    = r_n - 1'b1;
    assign q_pos   = q_frac(r_qi) * n_m1;
    assign q_lo    = ADDR_W'(q_pos[16 +: CNT_W]);
    assign snr     = 9'(r_rssi) - 9'(r_nf);

    // sequencer: next state, ram access and unit starts
    always_comb begin
        n_state      = r_state;
        ram_we       = 1'b0;
        ram_waddr    = r_j;
        ram_wdata    = r_amp;
        ram_raddr    = r_lo;
        sq_hs.start  = 1'b0;
        dv_hs.start  = 1'b0;
        sq_rad       = RAD_W'({r_energy, 16'd0});
        dv_dvd       = DVD_W'(r_asum);
        case (r_state)
            S_IDLE: begin
                sq_rad = RAD_W'({in_energy, 16'd0});
                if (s_acc) begin
                    if (r_pairs < CNT_W'(MAX_PAIRS)) begin
                        sq_hs.start = 1'b1;
                        n_state     = S_AMP;
                    end else if (i_s_tlast) begin
                        n_state = S_MEAN_GO;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_AMP: begin
                ram_raddr = ADDR_W'(r_pairs - 1'b1);
                if (sqd_done) begin
                    n_state = (r_pairs == '0) ? S_INS_LAST : S_INS;
                end
            end
            S_INS: begin
                ram_we = 1'b1;
                if (ram_rdata > r_amp) begin
                    ram_wdata = ram_rdata;
                    ram_raddr = r_j - ADDR_W'(2);
                    if (r_j == ADDR_W'(1)) begin
                        n_state = S_INS_LAST;
                    end
                end else begin
                    n_state = S_UPD;
                end
            end
            S_INS_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                n_state   = S_UPD;
            end
            S_UPD: begin
                n_state = r_last ? S_MEAN_GO : S_OUT;
            end
            S_MEAN_GO: begin
                dv_hs.start = 1'b1;
                n_state     = S_MEAN_WT;
            end
            S_MEAN_WT: begin
                if (dvd_done) begin
                    n_state = S_EX2_GO;
                end
            end
            S_EX2_GO: begin
                dv_dvd      = {r_ssum, 16'd0};
                dv_hs.start = 1'b1;
                n_state     = S_EX2_WT;
            end
            S_EX2_WT: begin
                if (dvd_done) begin
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                sq_rad      = RAD_W'(var_val);
                sq_hs.start = 1'b1;
                n_state     = S_SPR_WT;
            end
            S_SPR_WT: begin
                if (sqd_done) begin
                    n_state = S_QPOS;
                end
            end
            S_QPOS: begin
                n_state = S_QRDLO;
            end
            S_QRDLO: begin
                ram_raddr = r_lo;
                n_state   = S_QRDHI;
            end
            S_QRDHI: begin
                ram_raddr = r_hi;
                n_state   = S_QMUL;
            end
            S_QMUL: begin
                n_state = S_QSUM;
            end
            S_QSUM: begin
                n_state = (r_qi == QS_HIGH) ? S_OUT : S_QPOS;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state: counters, sums and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs  <= '0;
            r_asum   <= '0;
            r_ssum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_UPD) begin
                r_pairs <= r_pairs + 1'b1;
                r_asum  <= r_asum + SUM_W'(r_amp);
                r_ssum  <= r_ssum + SQ_W'(r_energy);
            end
            if (r_state == S_OUT && out_free && r_last) begin
                r_pairs <= '0;
                r_asum  <= '0;
                r_ssum  <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_last     <= i_s_tlast;
                    r_rssi     <= $signed(i_s_tdata[23:16]);
                    r_nf       <= $signed(i_s_tdata[31:24]);
                    r_energy   <= in_energy;
                    r_cnt_flag <= (r_pairs < CNT_W'(MAX_PAIRS));
                    r_amp      <= '0;
                    r_n        <= r_pairs;
                    r_j        <= ADDR_W'(r_pairs);
                end
            end
            S_AMP: begin
                r_amp <= sq_root[AMP_W-1:0];
            end
            S_INS: begin
                if (ram_rdata > r_amp) begin
                    r_j <= r_j - 1'b1;
                end
            end
            S_UPD: begin
                r_n <= r_pairs + 1'b1;
            end
            S_MEAN_WT: begin
                r_mean <= dv_quo[15:0];
            end
            S_EX2_GO: begin
                r_m2 <= r_mean * r_mean;
            end
            S_EX2_WT: begin
                r_ex2 <= dv_quo;
                r_qi  <= QS_LOW;
            end
            S_SPR_WT: begin
                r_spread <= sq_root[15:0];
            end
            S_QPOS: begin
                r_lo <= q_lo;
                r_t  <= q_pos[15:0];
                r_hi <= (CNT_W'(q_lo) + 1'b1 > n_m1) ? ADDR_W'(n_m1) : q_lo + 1'b1;
            end
            S_QRDHI: begin
                r_slo <= ram_rdata;
            end
            S_QMUL: begin
                r_pa <= r_slo * (17'h10000 - {1'b0, r_t});
                r_pb <= ram_rdata * r_t;
            end
            S_QSUM: begin
                case (r_qi)
                    QS_LOW:  r_ql <= 16'((34'(r_pa) + 34'(r_pb)) >> 16);
                    QS_MID:  r_qm <= 16'((34'(r_pa) + 34'(r_pb)) >> 16);
                    default: r_qh <= 16'((34'(r_pa) + 34'(r_pb)) >> 16);
                endcase
                case (r_qi)
                    QS_LOW:  r_qi <= QS_MID;
                    default: r_qi <= QS_HIGH;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    r_ouser <= r_cnt_flag;
                    r_olast <= r_last;
                    if (r_last) begin
                        r_odata <= {snr, r_qh, r_qm, r_ql, r_spread, r_mean,
                                    7'(r_n), r_amp};
                    end else begin
                        r_odata <= {96'd0, r_amp};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    iqas_ram #(
        .WIDTH (AMP_W),
        .DEPTH (MAX_PAIRS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    iqas_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hs       (sq_hs),
        .i_radicand (sq_rad),
        .o_done     (sqd_done),
        .o_root     (sq_root)
    );

    iqas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hs       (dv_hs),
        .i_dividend (dv_dvd),
        .i_divisor  (r_n),
        .o_done     (dvd_done),
        .o_quotient (dv_quo)
    );

    // count never passes the cap
    a_pairs_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= CNT_W'(MAX_PAIRS))
        else $error("pair count above cap");

    // insertion never writes past the current fill
    a_ins_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= r_pairs))
        else $error("store write beyond fill");

    // a packet end beat always has at least one counted pair
    a_end_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[22:16] != 7'd0))
        else $error("packet end with empty count");

    // statistics are zero on beats that do not end a packet
    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[111:16] == 96'd0))
        else $error("statistics on a non-final beat");

    // interpolated quantiles of a sorted store are ordered
    a_quant_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
            (o_m_tdata[70:55] <= o_m_tdata[86:71] &&
             o_m_tdata[86:71] <= o_m_tdata[102:87]))
        else $error("quantiles out of order");

endmodule
